>>> hw/rtl/pha_pkg.sv
// Shared constants, widths and the arctangent table for the heading block.
package pha_pkg;

   localparam int GUARD_BITS    = 24;
   localparam int TABLE_LEN     = 24;
   localparam int TABLE_IDX_W   = $clog2(TABLE_LEN);
   localparam int ANGLE_FRAC    = 8;
   localparam int ANGLE_WIDTH   = 26;
   localparam int HEADING_WIDTH = 16;
   localparam int ATAN_WIDTH    = 21;

   localparam logic signed [ANGLE_WIDTH-1:0] FULL_TURN  = ANGLE_WIDTH'(11796480);
   localparam logic signed [ANGLE_WIDTH-1:0] HALF_TURN  = ANGLE_WIDTH'(5898240);
   localparam logic signed [ANGLE_WIDTH-1:0] ROUND_HALF = ANGLE_WIDTH'(1 << (ANGLE_FRAC - 1));
   localparam logic [HEADING_WIDTH-1:0]      HEADING_MOD = HEADING_WIDTH'(46080);

   // atan(2^-i) in degrees, scaled by 32768, rounded to nearest
   function automatic logic [ATAN_WIDTH-1:0] atan_step(input logic [TABLE_IDX_W-1:0] idx);
      logic [ATAN_WIDTH-1:0] val;
      case (idx)
         5'd0:  val = ATAN_WIDTH'(1474560);
         5'd1:  val = ATAN_WIDTH'(870484);
         5'd2:  val = ATAN_WIDTH'(459940);
         5'd3:  val = ATAN_WIDTH'(233473);
         5'd4:  val = ATAN_WIDTH'(117189);
         5'd5:  val = ATAN_WIDTH'(58652);
         5'd6:  val = ATAN_WIDTH'(29333);
         5'd7:  val = ATAN_WIDTH'(14667);
         5'd8:  val = ATAN_WIDTH'(7334);
         5'd9:  val = ATAN_WIDTH'(3667);
         5'd10: val = ATAN_WIDTH'(1833);
         5'd11: val = ATAN_WIDTH'(917);
         5'd12: val = ATAN_WIDTH'(458);
         5'd13: val = ATAN_WIDTH'(229);
         5'd14: val = ATAN_WIDTH'(115);
         5'd15: val = ATAN_WIDTH'(57);
         5'd16: val = ATAN_WIDTH'(29);
         5'd17: val = ATAN_WIDTH'(14);
         5'd18: val = ATAN_WIDTH'(7);
         5'd19: val = ATAN_WIDTH'(4);
         5'd20: val = ATAN_WIDTH'(2);
         5'd21: val = ATAN_WIDTH'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> hw/rtl/pha_req_if.sv
// Request channel: vector components with valid/ready handshake.
interface pha_req_if #(
   parameter int COORD_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x_coord;
   logic signed [COORD_WIDTH-1:0] z_coord;

   modport source (output valid, output x_coord, output z_coord, input ready);
   modport sink   (input valid, input x_coord, input z_coord, output ready);
endinterface

>>> hw/rtl/pha_rsp_if.sv
// Response channel: heading and zero-vector flag with valid/ready handshake.
interface pha_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [pha_pkg::HEADING_WIDTH-1:0]   heading;
   logic                                zero_vector;

   modport source (output valid, output heading, output zero_vector, input ready);
   modport sink   (input valid, input heading, input zero_vector, output ready);
endinterface

>>> hw/rtl/planar_heading_angle.sv
// Heading of a planar vector: atan2(x, z) in 1/128 degree over [0, 360), by CORDIC vectoring.
//
// One request beat is taken when the block is idle. The response beat is offered once
// the rotations and the rounding are done: a single shift-add rotation unit runs one
// micro-rotation per cycle, then the round state does the wrap and rounding.
// The response beat is held until taken and the next request is accepted in the cycle
// after, so the block takes no new request while a response is pending. A zero
// vector returns heading 0 with zero_vector set. Headings that round to a full turn
// read as 0.
module planar_heading_angle #(
   parameter int COORD_WIDTH = 16,
   parameter int ITERATIONS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   pha_req_if.sink   req,
   pha_rsp_if.source rsp
);
   import pha_pkg::*;

   localparam int DW    = COORD_WIDTH + GUARD_BITS + 3;
   localparam int CNT_W = $clog2(ITERATIONS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ITERATIONS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_ROUND,
      ST_RESULT
   } state_type;

   state_type                     state_ff;
   logic        [CNT_W-1:0]       step_ff;
   logic signed [DW-1:0]          a_ff;
   logic signed [DW-1:0]          b_ff;
   logic signed [ANGLE_WIDTH-1:0] acc_ff;
   logic                          zero_ff;
   logic [HEADING_WIDTH-1:0]      heading_ff;

   // initial fold into the right half plane
   logic signed [DW-1:0] a_start;
   logic signed [DW-1:0] b_start;
   logic                 z_neg;
   logic                 is_zero;

   assign z_neg   = req.z_coord[COORD_WIDTH-1];
   assign is_zero = (req.x_coord == '0) && (req.z_coord == '0);
   assign a_start = {{(DW-COORD_WIDTH-GUARD_BITS){req.z_coord[COORD_WIDTH-1]}},
                     req.z_coord, {GUARD_BITS{1'b0}}};
   assign b_start = {{(DW-COORD_WIDTH-GUARD_BITS){req.x_coord[COORD_WIDTH-1]}},
                     req.x_coord, {GUARD_BITS{1'b0}}};

   // shared rotation unit
   logic signed [DW-1:0]          a_shift;
   logic signed [DW-1:0]          b_shift;
   logic signed [ANGLE_WIDTH-1:0] atan_val;
   logic signed [DW-1:0]          a_next;
   logic signed [DW-1:0]          b_next;
   logic signed [ANGLE_WIDTH-1:0] acc_next;

   assign a_shift  = a_ff >>> step_ff;
   assign b_shift  = b_ff >>> step_ff;
   assign atan_val = signed'(ANGLE_WIDTH'(atan_step(TABLE_IDX_W'(step_ff))));

   always_comb begin
      if (!b_ff[DW-1]) begin
         a_next   = a_ff + b_shift;
         b_next   = b_ff - a_shift;
         acc_next = acc_ff + atan_val;
      end else begin
         a_next   = a_ff - b_shift;
         b_next   = b_ff + a_shift;
         acc_next = acc_ff - atan_val;
      end
   end

   // wrap into one turn and round to 1/128 degree
   logic signed [ANGLE_WIDTH-1:0] acc_wrap;
   logic signed [ANGLE_WIDTH-1:0] acc_round;
   logic [HEADING_WIDTH-1:0]      heading_raw;

   always_comb begin
      if (acc_ff[ANGLE_WIDTH-1]) begin
         acc_wrap = acc_ff + FULL_TURN;
      end else if (acc_ff >= FULL_TURN) begin
         acc_wrap = acc_ff - FULL_TURN;
      end else begin
         acc_wrap = acc_ff;
      end
      acc_round   = acc_wrap + ROUND_HALF;
      heading_raw = acc_round[ANGLE_FRAC +: HEADING_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  state_ff <= ST_ROTATE;
                  step_ff  <= '0;
                  zero_ff  <= is_zero;
                  a_ff     <= z_neg ? -a_start : a_start;
                  b_ff     <= z_neg ? -b_start : b_start;
                  acc_ff   <= z_neg ? HALF_TURN : '0;
               end
            end
            ST_ROTATE: begin
               a_ff    <= a_next;
               b_ff    <= b_next;
               acc_ff  <= acc_next;
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               if (zero_ff || (heading_raw >= HEADING_MOD)) begin
                  heading_ff <= '0;
               end else begin
                  heading_ff <= heading_raw;
               end
               state_ff <= ST_RESULT;
            end
            ST_RESULT: begin
               if (rsp.ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req.ready       = (state_ff == ST_IDLE);
   assign rsp.valid       = (state_ff == ST_RESULT);
   assign rsp.heading     = heading_ff;
   assign rsp.zero_vector = zero_ff;

endmodule

>>> test/tb_planar_heading_angle.sv
// Self-checking testbench for planar_heading_angle: CORDIC heading predictor with random stalls.
module tb_planar_heading_angle;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W = 16;
   localparam int ITER    = 16;
   localparam int DRAIN   = 3 * (ITER + 2);
   localparam longint ANGLE_FULL = 64'sd11796480;   // 360 deg * 32768
   localparam longint ANGLE_HALF = 64'sd5898240;
   localparam longint WRAP_HEADING = 64'sd46080;

   // atan(2^-i) in degrees, scaled by 32768
   localparam longint ATAN_DEG [24] = '{
      1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
      7334, 3667, 1833, 917, 458, 229, 115, 57,
      29, 14, 7, 4, 2, 1, 0, 0
   };

   localparam logic signed [COORD_W-1:0] CORNER_VALS [6] = '{
      -16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
   };

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] z;
   } vec_type;

   typedef struct packed {
      vec_type                             src;
      logic [pha_pkg::HEADING_WIDTH-1:0]   heading;
      logic                                zero_vector;
   } heading_type;

   logic clock = 1'b0;
   logic reset;

   pha_req_if #(.COORD_WIDTH(COORD_W)) req_if ();
   pha_rsp_if rsp_if ();

   planar_heading_angle #(
      .COORD_WIDTH(COORD_W),
      .ITERATIONS (ITER)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if)
   );

   vec_type     pending_vectors[$];
   heading_type expected_headings[$];
   int          vec_total      = 0;
   int          vec_accepted   = 0;
   int          gap_left;
   int          hold_left;
   int          headings_seen  = 0;
   bit          long_hold_done = 1'b0;
   int          errors         = 0;

   always #5 clock = ~clock;

   function automatic heading_type predict_heading(vec_type v);
      heading_type res;
      longint      a, b, acc, da, db, h;
      res.src         = v;
      res.heading     = '0;
      res.zero_vector = 1'b0;
      if (v.x == 0 && v.z == 0) begin
         res.zero_vector = 1'b1;
         return res;
      end
      a   = longint'($signed(v.z)) * (longint'(1) << pha_pkg::GUARD_BITS);
      b   = longint'($signed(v.x)) * (longint'(1) << pha_pkg::GUARD_BITS);
      acc = 0;
      if (v.z < 0) begin
         a   = -a;
         b   = -b;
         acc = ANGLE_HALF;
      end
      for (int i = 0; i < ITER && i < 24; i++) begin
         da = b >>> i;
         db = a >>> i;
         if (b >= 0) begin
            a   = a + da;
            b   = b - db;
            acc = acc + ATAN_DEG[i];
         end else begin
            a   = a - da;
            b   = b + db;
            acc = acc - ATAN_DEG[i];
         end
      end
      if (acc < 0) acc = acc + ANGLE_FULL;
      if (acc >= ANGLE_FULL) acc = acc - ANGLE_FULL;
      h = (acc + 128) >>> 8;
      if (h >= WRAP_HEADING) h = 0;
      res.heading = h[15:0];
      return res;
   endfunction

   // mostly short gaps, a few long ones; some stretches run flat out
   function automatic int pick_gap(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic vec_type random_vector();
      vec_type v;
      int      m;
      int      t;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            v.x = COORD_W'($urandom);
            v.z = COORD_W'($urandom);
         end
         4, 5: begin
            t   = int'($urandom_range(0, 16)) - 8;
            v.x = COORD_W'(t);
            t   = int'($urandom_range(0, 16)) - 8;
            v.z = COORD_W'(t);
         end
         6: begin
            t = int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1)) begin
               v.x = COORD_W'(t);
               v.z = COORD_W'($urandom);
            end else begin
               v.z = COORD_W'(t);
               v.x = COORD_W'($urandom);
            end
         end
         7: begin
            m   = $urandom_range(1, 32767);
            v.x = $urandom_range(0, 1) ? COORD_W'(m) : COORD_W'(-m);
            v.z = $urandom_range(0, 1) ? COORD_W'(m) : COORD_W'(-m);
         end
         8: begin
            v.x = CORNER_VALS[$urandom_range(0, 5)];
            v.z = CORNER_VALS[$urandom_range(0, 5)];
         end
         default: begin
            // just short of a full turn, where rounding may wrap to zero
            t   = -int'($urandom_range(1, 3));
            v.x = COORD_W'(t);
            v.z = COORD_W'($urandom_range(1, 32767));
         end
      endcase
      return v;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.x_coord <= '0;
         req_if.z_coord <= '0;
         gap_left       <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_headings.push_back(predict_heading(vec_type'{x: req_if.x_coord,
                                                                  z: req_if.z_coord}));
            vec_accepted = vec_accepted + 1;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               req_if.valid <= 1'b0;
               gap_left     <= gap_left - 1;
            end else if (pending_vectors.size() > 0) begin
               req_if.valid   <= 1'b1;
               req_if.x_coord <= pending_vectors[0].x;
               req_if.z_coord <= pending_vectors[0].z;
               gap_left       <= pick_gap(((pending_vectors.size() / 80) % 4) == 1);
               void'(pending_vectors.pop_front());
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_headings.size() == 0) begin
               $display("%0t: unexpected beat heading=%0d zero_vector=%0b", $time,
                        rsp_if.heading, rsp_if.zero_vector);
               errors = errors + 1;
            end else begin
               if (rsp_if.heading !== expected_headings[0].heading) begin
                  $display("%0t: heading mismatch x=%0d z=%0d: expected %0d, actual %0d",
                           $time, expected_headings[0].src.x, expected_headings[0].src.z,
                           expected_headings[0].heading, rsp_if.heading);
                  errors = errors + 1;
               end
               if (rsp_if.zero_vector !== expected_headings[0].zero_vector) begin
                  $display("%0t: zero_vector mismatch x=%0d z=%0d: expected %0b, actual %0b",
                           $time, expected_headings[0].src.x, expected_headings[0].src.z,
                           expected_headings[0].zero_vector, rsp_if.zero_vector);
                  errors = errors + 1;
               end
               void'(expected_headings.pop_front());
            end
            headings_seen <= headings_seen + 1;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
         end else if (!long_hold_done && headings_seen >= 150) begin
            // long hold-off so the block backs up and stalls the request side
            rsp_if.ready   <= 1'b0;
            hold_left      <= 400;
            long_hold_done <= 1'b1;
         end else begin
            hold_left    <= pick_gap(((headings_seen / 70) % 4) == 2);
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      vec_type v;
      reset = 1'b1;

      // directed: axes, corners, zero vector, wrap to zero, x = 0 with negative z
      pending_vectors.push_back(vec_type'{x: 16'sd0,      z: 16'sd0});
      pending_vectors.push_back(vec_type'{x: 16'sd0,      z: 16'sd1});
      pending_vectors.push_back(vec_type'{x: 16'sd1,      z: 16'sd0});
      pending_vectors.push_back(vec_type'{x: 16'sd0,      z: -16'sd1});
      pending_vectors.push_back(vec_type'{x: -16'sd1,     z: 16'sd0});
      pending_vectors.push_back(vec_type'{x: 16'sd0,      z: 16'sd32767});
      pending_vectors.push_back(vec_type'{x: 16'sd0,      z: -16'sd32768});
      pending_vectors.push_back(vec_type'{x: 16'sd32767,  z: 16'sd0});
      pending_vectors.push_back(vec_type'{x: -16'sd32768, z: 16'sd0});
      pending_vectors.push_back(vec_type'{x: 16'sd32767,  z: 16'sd32767});
      pending_vectors.push_back(vec_type'{x: -16'sd32768, z: -16'sd32768});
      pending_vectors.push_back(vec_type'{x: 16'sd32767,  z: -16'sd32768});
      pending_vectors.push_back(vec_type'{x: -16'sd32768, z: 16'sd32767});
      pending_vectors.push_back(vec_type'{x: -16'sd1,     z: 16'sd32767});
      pending_vectors.push_back(vec_type'{x: -16'sd1,     z: 16'sd1000});
      pending_vectors.push_back(vec_type'{x: 16'sd1,      z: -16'sd32768});
      pending_vectors.push_back(vec_type'{x: -16'sd1,     z: -16'sd32768});
      pending_vectors.push_back(vec_type'{x: 16'sd1,      z: 16'sd1});
      pending_vectors.push_back(vec_type'{x: -16'sd1,     z: -16'sd1});
      pending_vectors.push_back(vec_type'{x: 16'sd0,      z: -16'sd5});
      pending_vectors.push_back(vec_type'{x: 16'sd0,      z: 16'sd0});
      for (int n = 0; n < 700; n++) begin
         v = random_vector();
         pending_vectors.push_back(v);
      end
      vec_total = pending_vectors.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (vec_accepted < vec_total) @(posedge clock);
      while (expected_headings.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (errors == 0 && expected_headings.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("%0t: timeout", $time);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/pha_pkg.sv
hw/rtl/pha_req_if.sv
hw/rtl/pha_rsp_if.sv
hw/rtl/planar_heading_angle.sv
test/tb_planar_heading_angle.sv
